>>> hw/rtl/piecewise_linear_interpolator_defines.svh
// Assertion helpers, used by the controller (pli_ctrl.sv).
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PLI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must be stable in the cycle after a condition.
`define PLI_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

>>> hw/rtl/pli_pkg.sv
package pli_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [1:0] ReqClear = 2'd0;
  localparam logic [1:0] ReqLoad  = 2'd1;
  localparam logic [1:0] ReqQuery = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFew   = 2'd2;
  localparam logic [1:0] StFull  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       take;      // capture input item
    logic       rd_en;     // read memories at rd_addr
    logic [IdxW-1:0] rd_addr;
    logic       wr_en;
    logic [IdxW-1:0] wr_addr;
    logic       wr_sel_in; // write the captured item (else the last read entry)
    logic       lat_lo;    // read data is lower point
    logic       lat_hi;    // read data is upper point
    logic       lat_first; // read data is first key
    logic       mul_go;
    logic       div_start;
    logic       div_step;
    logic       res_ok;    // result from quotient
    logic       res_zero;  // result zero with status
    logic [1:0] res_status;
    logic       res_v0;    // result is lower value
  } pli_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req;
    logic       rd_key_le; // read key <= item key
    logic       rd_key_lt; // read key < item key
    logic       key_lt_first;
    logic       span_zero;
  } pli_sts_t;

endpackage

>>> hw/rtl/pli_ram.sv
module pli_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule

>>> hw/rtl/pli_datapath.sv
module pli_datapath (
  input  logic             clk_i,
  input  pli_pkg::pli_cmd_t cmd_i,
  output pli_pkg::pli_sts_t sts_o,
  input  logic [33:0]      item_i,   // req_type, key_in, value_in
  output logic [17:0]      result_o, // value_out, status
  output logic             div_bit_o
);
  import pli_pkg::*;

  logic [1:0]         req_q;
  logic signed [15:0] key_q, val_q;
  logic signed [15:0] k0_q, v0_q, k1_q, v1_q, first_q;
  logic [15:0]        rk, rv;
  logic signed [34:0] prod_q;      // (key-k0)*(v1-v0), fits in 35 bits
  logic [33:0]        rem_q, quo_q;
  logic [16:0]        den_q;       // |k1-k0|
  logic               neg_q;
  logic [5:0]         cnt_q;
  logic [15:0]        res_val_q;
  logic [1:0]         res_st_q;

  logic signed [16:0] dk, dv, span;
  logic [34:0]        trial;
  logic signed [34:0] qs;

  pli_ram #(.Width(16), .Depth(TableDepth)) u_keys (
    .clk_i, .wr_en_i(cmd_i.wr_en), .wr_addr_i(cmd_i.wr_addr),
    .wr_data_i(cmd_i.wr_sel_in ? key_q : rk),
    .rd_en_i(cmd_i.rd_en), .rd_addr_i(cmd_i.rd_addr), .rd_data_o(rk)
  );
  pli_ram #(.Width(16), .Depth(TableDepth)) u_vals (
    .clk_i, .wr_en_i(cmd_i.wr_en), .wr_addr_i(cmd_i.wr_addr),
    .wr_data_i(cmd_i.wr_sel_in ? val_q : rv),
    .rd_en_i(cmd_i.rd_en), .rd_addr_i(cmd_i.rd_addr), .rd_data_o(rv)
  );

  assign dk   = 17'(key_q) - 17'(k0_q);
  assign dv   = 17'(v1_q) - 17'(v0_q);
  assign span = 17'(k1_q) - 17'(k0_q);
  assign trial = {rem_q, quo_q[33]} - {18'd0, den_q};
  assign qs = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q <= item_i[1:0];
      key_q <= item_i[17:2];
      val_q <= item_i[33:18];
    end
    if (cmd_i.lat_lo) begin
      k0_q <= rk;
      v0_q <= rv;
    end
    if (cmd_i.lat_hi) begin
      k1_q <= rk;
      v1_q <= rv;
    end
    if (cmd_i.lat_first) begin
      first_q <= rk;
    end
    if (cmd_i.mul_go) begin
      prod_q <= 35'(dk) * 35'(dv);
    end
    if (cmd_i.div_start) begin
      // span is non-negative since k0 <= k1
      neg_q <= prod_q[34];
      quo_q <= prod_q[34] ? 34'(-prod_q) : 34'(prod_q);
      rem_q <= '0;
      den_q <= span[16:0];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[34]) begin
        rem_q <= trial[33:0];
        quo_q <= {quo_q[32:0], 1'b1};
      end else begin
        rem_q <= {rem_q[32:0], quo_q[33]};
        quo_q <= {quo_q[32:0], 1'b0};
      end
      cnt_q <= cnt_q + 6'd1;
    end
    if (cmd_i.res_ok) begin
      res_val_q <= 16'(v0_q + qs[15:0]);
      res_st_q  <= StOk;
    end else if (cmd_i.res_v0) begin
      res_val_q <= v0_q;
      res_st_q  <= StOk;
    end else if (cmd_i.res_zero) begin
      res_val_q <= '0;
      res_st_q  <= cmd_i.res_status;
    end
  end

  assign sts_o.req          = req_q;
  assign sts_o.rd_key_le    = $signed(rk) <= key_q;
  assign sts_o.rd_key_lt    = $signed(rk) < key_q;
  assign sts_o.key_lt_first = key_q < first_q;
  assign sts_o.span_zero    = (span == '0);
  assign result_o  = {res_st_q, res_val_q};
  assign div_bit_o = (cnt_q == 6'd33);
endmodule

>>> hw/rtl/pli_ctrl.sv
`include "piecewise_linear_interpolator_defines.svh"
module pli_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pli_pkg::pli_sts_t sts_i,
  input  logic              div_last_i,
  output pli_pkg::pli_cmd_t cmd_o
);
  import pli_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDisp   = 4'd1;
  localparam logic [3:0] SLdScan = 4'd2;  // scan up for insert position
  localparam logic [3:0] SLdShft = 4'd3;  // shift entries up from top
  localparam logic [3:0] SLdPut  = 4'd4;
  localparam logic [3:0] SQFirst = 4'd5;
  localparam logic [3:0] SQLast  = 4'd6;
  localparam logic [3:0] SQScan  = 4'd7;
  localparam logic [3:0] SQLo    = 4'd8;
  localparam logic [3:0] SQMul   = 4'd9;
  localparam logic [3:0] SQDiv   = 4'd10;
  localparam logic [3:0] SQRes   = 4'd11;
  localparam logic [3:0] SOut    = 4'd12;
  localparam logic [3:0] SQDivS  = 4'd13;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          cmd_o.take = 1'b1;
          state_d = SDisp;
        end
      end
      SDisp: begin
        case (sts_i.req)
          ReqClear: begin
            count_d = '0;
            cmd_o.res_zero = 1'b1; cmd_o.res_status = StOk;
            state_d = SOut;
          end
          ReqLoad: begin
            if (count_q == CntW'(TableDepth)) begin
              cmd_o.res_zero = 1'b1; cmd_o.res_status = StFull;
              state_d = SOut;
            end else if (count_q == '0) begin
              ptr_d = '0;
              state_d = SLdPut;
            end else begin
              cmd_o.rd_en = 1'b1; cmd_o.rd_addr = '0;
              ptr_d = '0;
              state_d = SLdScan;
            end
          end
          ReqQuery: begin
            if (count_q < CntW'(2)) begin
              cmd_o.res_zero = 1'b1; cmd_o.res_status = StFew;
              state_d = SOut;
            end else begin
              cmd_o.rd_en = 1'b1; cmd_o.rd_addr = '0;
              state_d = SQFirst;
            end
          end
          default: begin
            cmd_o.res_zero = 1'b1; cmd_o.res_status = StOk;
            state_d = SOut;
          end
        endcase
      end
      SLdScan: begin
        // rk holds entry ptr
        if (sts_i.rd_key_le) begin
          if (ptr_q + 1'b1 == count_q) begin
            ptr_d = count_q;
            state_d = SLdPut;
          end else begin
            ptr_d = ptr_q + 1'b1;
            cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(ptr_q + 1'b1);
          end
        end else begin
          // insert at ptr; shift from count-1 down to ptr
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(count_q - 1'b1);
          ov_d = 1'b0;
          state_d = SLdShft;
          count_d = count_q; // unchanged, ptr holds position
          ptr_d = ptr_q;
        end
      end
      SLdShft: begin
        // read data = entry at (count-1 - shifted); use ov_q as unused; track via wr
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_addr = IdxW'(count_q);
        if (count_q - 1'b1 == ptr_q) begin
          state_d = SLdPut;
        end else begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(count_q - CntW'(2));
        end
        count_d = count_q - 1'b1;
        ov_d = 1'b1;
      end
      SLdPut: begin
        cmd_o.wr_en = 1'b1; cmd_o.wr_sel_in = 1'b1; cmd_o.wr_addr = IdxW'(ptr_q);
        cmd_o.res_zero = 1'b1; cmd_o.res_status = StOk;
        state_d = SOut;
      end
      SQFirst: begin
        cmd_o.lat_first = 1'b1;
        cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(count_q - 1'b1);
        state_d = SQLast;
      end
      SQLast: begin
        if (sts_i.key_lt_first || sts_i.rd_key_lt) begin
          cmd_o.res_zero = 1'b1; cmd_o.res_status = StRange;
          state_d = SOut;
        end else begin
          ptr_d = CntW'(1);
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(1);
          state_d = SQScan;
        end
      end
      SQScan: begin
        if (ptr_q < count_q - 1'b1 && sts_i.rd_key_lt) begin
          ptr_d = ptr_q + 1'b1;
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(ptr_q + 1'b1);
        end else begin
          cmd_o.lat_hi = 1'b1;
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(ptr_q - 1'b1);
          state_d = SQLo;
        end
      end
      SQLo: begin
        cmd_o.lat_lo = 1'b1;
        state_d = SQMul;
      end
      SQMul: begin
        if (sts_i.span_zero) begin
          cmd_o.res_v0 = 1'b1;
          state_d = SOut;
        end else begin
          cmd_o.mul_go = 1'b1;
          state_d = SQDivS;
        end
      end
      SQDivS: begin
        cmd_o.div_start = 1'b1;
        state_d = SQDiv;
      end
      SQDiv: begin
        cmd_o.div_step = 1'b1;
        if (div_last_i) begin
          state_d = SQRes;
        end
      end
      SQRes: begin
        cmd_o.res_ok = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        ov_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    if (state_q == SDisp && sts_i.req == ReqLoad && count_q != CntW'(TableDepth)) begin
      count_d = count_q; // bumped at SLdPut below
    end
    if (state_q == SLdPut) begin
      count_d = count_q + 1'b1;
    end
    if (state_q == SLdShft) begin
      ov_d = ov_q;
    end
    if (out_valid_o && out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  // shift walks count down as the top pointer; top_q saves the old count, restored
  logic [CntW-1:0] top_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      ptr_q   <= '0;
      ov_q    <= 1'b0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      ov_q    <= ov_d;
      if (state_q == SLdScan && state_d == SLdShft) begin
        top_q <= count_q;
      end
      if (state_q == SLdShft && state_d == SLdPut) begin
        count_q <= top_q;
      end else begin
        count_q <= count_d;
      end
    end
  end

  assign out_valid_o = ov_q && state_q == SIdle;

  `PLI_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CntW'(TableDepth), "count over depth")
  `PLI_ASSERT(a_no_take_busy, clk_i, rst_ni, cmd_o.take |-> state_q == SIdle, "take when busy")
  `PLI_ASSERT_HOLD(a_res_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
                   "result dropped")
endmodule

>>> hw/rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolation table.
// Input stream s_axis: tdata = {value_in, key_in, req_type}; req 0 clears,
// 1 loads a breakpoint (sorted insert after equal keys), 2 queries, 3 gives zero.
// Output stream m_axis: tdata = {status, value_out}, one item per input item.
// Items are processed one at a time. Clear, too few points and a full table
// answer straight from dispatch; a key out of range is found once the first
// and last keys are read. A load scans the key memory once to its position,
// then shifts the entries above it up one per cycle. A query reads the end
// points, scans for the segment, multiplies once and runs a 34-step restoring
// divider (a zero span skips the multiply and divide and gives the lower
// value). One memory read per cycle sets the scan and shift rate. The next
// item can be accepted in the cycle after the result is taken.
// The input is not accepted while a result waits; a stalled receiver holds
// the block with its result stable.
// Reset empties the table at once; memory contents are left as they are.
module piecewise_linear_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // req_type[1:0], key_in[17:2], value_in[33:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // value_out[15:0], status[17:16]
);
  import pli_pkg::*;

  pli_cmd_t    cmd;
  pli_sts_t    sts;
  logic [17:0] result;
  logic        div_last;

  pli_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .div_last_i(div_last), .cmd_o(cmd)
  );

  pli_datapath u_dp (
    .clk_i, .cmd_i(cmd), .sts_o(sts),
    .item_i(s_axis_tdata[33:0]), .result_o(result), .div_bit_o(div_last)
  );

  assign m_axis_tdata = {6'd0, result};
endmodule
